/* rtl/dpp_pkg.sv */
// Shared widths, constants and helper functions for the depth pixel to point pipeline.
package dpp_pkg;

   localparam int RATIO_FRAC_BITS = 16;

   localparam int DEPTH_W  = 16;
   localparam int IDX_W    = 12;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int LAT_W    = 20;
   localparam int RANGE_W  = 16;
   localparam int NUM_W    = 16;

   // Ratio magnitude, Q12.RATIO_FRAC_BITS.
   localparam int RATIO_W  = RATIO_FRAC_BITS + 12;
   localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};

   // Ratio magnitude converted to Q.16 is always 28 bits wide.
   localparam int Q16_W    = 28;
   localparam int Q16_SHR  = (RATIO_FRAC_BITS >= 16) ? RATIO_FRAC_BITS - 16 : 0;
   localparam int Q16_SHL  = (RATIO_FRAC_BITS >= 16) ? 0 : 16 - RATIO_FRAC_BITS;

   // Sum of squares and its root.
   localparam int SQR_W    = 2 * Q16_W;
   localparam int SQ_IW    = SQR_W + 2;
   localparam int ROOT_W   = SQ_IW / 2;
   localparam int SQ_RW    = ROOT_W + 3;
   localparam logic [SQ_IW-1:0] NORM_ONE_SQ = SQ_IW'(1) << 32;

   // Shared divider geometry: wide enough for both the ratio and the range division.
   localparam int DIV_NW   = (NUM_W + RATIO_FRAC_BITS > 32) ? NUM_W + RATIO_FRAC_BITS : 32;
   localparam int DIV_DW   = (ROOT_W > CSR_W) ? ROOT_W : CSR_W;

   localparam int PROD_W   = RATIO_W + DEPTH_W;
   localparam int PSH_W    = PROD_W - RATIO_FRAC_BITS;
   localparam logic [LAT_W-1:0] LAT_MAX = {1'b0, {(LAT_W-1){1'b1}}};
   localparam logic [LAT_W-1:0] LAT_MIN = {1'b1, {(LAT_W-1){1'b0}}};

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_X  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_Y  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 2'd3;

   localparam logic [CSR_W-1:0] FOCAL_X_RST  = 16'd9600;
   localparam logic [CSR_W-1:0] FOCAL_Y_RST  = 16'd9600;
   localparam logic [CSR_W-1:0] CENTER_X_RST = 16'd6784;
   localparam logic [CSR_W-1:0] CENTER_Y_RST = 16'd3840;

   // Convert a ratio magnitude to Q.16, truncating.
   function automatic logic [Q16_W-1:0] to_q16(input logic [RATIO_W-1:0] mag);
      logic [RATIO_W+15:0] t;
      t = {16'b0, mag} >> Q16_SHR;
      t = t << Q16_SHL;
      return t[Q16_W-1:0];
   endfunction

endpackage

/* rtl/dpp_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module dpp_div
   import dpp_pkg::*;
(
   input  logic              clock,
   input  logic              adv,
   input  logic [DIV_NW-1:0] dividend,
   input  logic [DIV_DW-1:0] divisor,
   output logic [DIV_NW-1:0] quotient
);

   logic [DIV_DW-1:0] rem_ff [DIV_NW];
   logic [DIV_DW-1:0] rem_in [DIV_NW];
   logic [DIV_DW-1:0] den_ff [DIV_NW];
   logic [DIV_DW-1:0] den_in [DIV_NW];
   logic [DIV_NW-1:0] num_ff [DIV_NW];
   logic [DIV_NW-1:0] num_in [DIV_NW];
   logic [DIV_NW-1:0] quo_ff [DIV_NW];
   logic [DIV_NW-1:0] quo_in [DIV_NW];

   always_comb begin
      logic [DIV_DW-1:0] rem_prev;
      logic [DIV_DW-1:0] den_prev;
      logic [DIV_NW-1:0] num_prev;
      logic [DIV_NW-1:0] quo_prev;
      logic [DIV_DW:0]   trial;
      for (int k = 0; k < DIV_NW; k++) begin
         if (k == 0) begin
            rem_prev = '0;
            den_prev = divisor;
            num_prev = dividend;
            quo_prev = '0;
         end else begin
            rem_prev = rem_ff[k-1];
            den_prev = den_ff[k-1];
            num_prev = num_ff[k-1];
            quo_prev = quo_ff[k-1];
         end
         trial = {rem_prev, num_prev[DIV_NW-1]};
         if (trial >= {1'b0, den_prev}) begin
            rem_in[k] = DIV_DW'(trial - {1'b0, den_prev});
            quo_in[k] = {quo_prev[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[DIV_DW-1:0];
            quo_in[k] = {quo_prev[DIV_NW-2:0], 1'b0};
         end
         num_in[k] = num_prev << 1;
         den_in[k] = den_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         den_ff <= den_in;
         num_ff <= num_in;
         quo_ff <= quo_in;
      end
   end

   assign quotient = quo_ff[DIV_NW-1];

endmodule

/* rtl/dpp_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
module dpp_isqrt
   import dpp_pkg::*;
(
   input  logic              clock,
   input  logic              adv,
   input  logic [SQ_IW-1:0]  radicand,
   output logic [ROOT_W-1:0] root
);

   logic [SQ_IW-1:0]  x_ff    [ROOT_W];
   logic [SQ_IW-1:0]  x_in    [ROOT_W];
   logic [SQ_RW-1:0]  rem_ff  [ROOT_W];
   logic [SQ_RW-1:0]  rem_in  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [ROOT_W-1:0] root_in [ROOT_W];

   always_comb begin
      logic [SQ_IW-1:0]  x_prev;
      logic [SQ_RW-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [SQ_RW-1:0]  remt;
      logic [SQ_RW-1:0]  trial;
      for (int k = 0; k < ROOT_W; k++) begin
         if (k == 0) begin
            x_prev    = radicand;
            rem_prev  = '0;
            root_prev = '0;
         end else begin
            x_prev    = x_ff[k-1];
            rem_prev  = rem_ff[k-1];
            root_prev = root_ff[k-1];
         end
         remt  = {rem_prev[SQ_RW-3:0], x_prev[SQ_IW-1 -: 2]};
         trial = {1'b0, root_prev, 2'b01};
         if (remt >= trial) begin
            rem_in[k]  = remt - trial;
            root_in[k] = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = remt;
            root_in[k] = {root_prev[ROOT_W-2:0], 1'b0};
         end
         x_in[k] = x_prev << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff    <= x_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

/* rtl/depth_pixel_to_point.sv */
// Top level of the depth pixel to point back-projection pipeline.
//
// Each item on the req_ channel is one depth pixel with its row and column index
// and a frame marker. The block returns exactly one item on the rsp_ channel per
// pixel: the two lateral terms (ratio times depth, saturated) and the range scaled
// by 1/sqrt(1+a^2+b^2), with frame_end copied from frame_last.
// Both channels use valid/ready. The block is a single pipeline of 98 register
// stages. One pixel is accepted every cycle while the receiver does not stall;
// the rate is set by the fully pipelined dividers (one quotient bit per stage)
// and square root (one root bit per stage).
// When the receiver stalls with a result waiting in the output register, the
// whole pipeline holds and req_ready drops in the same cycle; nothing is lost or
// repeated, and empty stages ahead of the output keep filling only once it moves.
// Reset clears the pipeline valid bits and returns the four calibration registers
// (focal_x, focal_y, center_x, center_y) to their defaults. The csr_ port writes a
// register; the user must write one only while no item is in flight; it is not enforced.
module depth_pixel_to_point
   import dpp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [DEPTH_W-1:0]   req_depth_sample,
   input  logic [IDX_W-1:0]     req_pixel_row,
   input  logic [IDX_W-1:0]     req_pixel_col,
   input  logic                 req_frame_last,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [LAT_W-1:0] rsp_lateral_col,
   output logic signed [LAT_W-1:0] rsp_lateral_row,
   output logic [RANGE_W-1:0]   rsp_range_scaled,
   output logic                 rsp_frame_end,

   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // Stage positions in the valid chain.
   localparam int P3_IDX   = DIV_NW + 3;
   localparam int SQO_IDX  = P3_IDX + ROOT_W;
   localparam int DIVB_IDX = SQO_IDX + DIV_NW;
   localparam int LAT      = DIVB_IDX + 2;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic               last;
      logic               a_neg;
      logic               a_nz;
      logic               b_neg;
      logic               b_nz;
   } side1_type;

   typedef struct packed {
      logic [LAT_W-1:0]   lat_col;
      logic [LAT_W-1:0]   lat_row;
      logic [DEPTH_W-1:0] depth;
      logic               last;
   } side2_type;

   typedef struct packed {
      logic [LAT_W-1:0]   lat_col;
      logic [LAT_W-1:0]   lat_row;
      logic               last;
   } side3_type;

   // Clamp a raw ratio quotient; a zero focal length saturates unless the numerator is zero.
   function automatic logic [RATIO_W-1:0] clamp_ratio(input logic [DIV_NW-1:0] q,
                                                      input logic [CSR_W-1:0]  focal,
                                                      input logic              nz);
      logic [RATIO_W-1:0] r;
      if (focal == '0) begin
         r = nz ? RATIO_MAX : '0;
      end else if (q > DIV_NW'(RATIO_MAX)) begin
         r = RATIO_MAX;
      end else begin
         r = q[RATIO_W-1:0];
      end
      return r;
   endfunction

   // Drop the fraction, saturate the magnitude and apply the sign.
   function automatic logic [LAT_W-1:0] lateral(input logic [PROD_W-1:0] prod,
                                                input logic              neg);
      logic [PSH_W-1:0] p;
      logic [LAT_W-1:0] m;
      p = prod[PROD_W-1:RATIO_FRAC_BITS];
      m = (p[PSH_W-1:LAT_W-1] != '0) ? LAT_MAX : p[LAT_W-1:0];
      return neg ? LAT_W'(-m) : m;
   endfunction

   // Calibration registers.
   logic [CSR_W-1:0] focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff  <= FOCAL_X_RST;
         focal_y_ff  <= FOCAL_Y_RST;
         center_x_ff <= CENTER_X_RST;
         center_y_ff <= CENTER_Y_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_FOCAL_X:  focal_x_ff  <= csr_wdata;
            CSR_FOCAL_Y:  focal_y_ff  <= csr_wdata;
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The whole pipeline moves together whenever the output register can move.
   logic adv;
   logic [LAT-1:0] vld_ff, vld_in;

   assign adv       = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[LAT-1];
   assign vld_in    = {vld_ff[LAT-2:0], req_valid && req_ready};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Stage 0: capture the pixel.
   logic [DEPTH_W-1:0] in_depth_ff;
   logic [IDX_W-1:0]   in_row_ff, in_col_ff;
   logic               in_last_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         in_depth_ff <= req_depth_sample;
         in_row_ff   <= req_pixel_row;
         in_col_ff   <= req_pixel_col;
         in_last_ff  <= req_frame_last;
      end
   end

   // Signed numerators center - (index << 4), split into sign and magnitude.
   logic [NUM_W-1:0] pos_a, pos_b, num_a, num_b;
   logic             neg_a, neg_b;
   side1_type        s1_in;

   always_comb begin
      pos_a = {in_row_ff, 4'b0};
      pos_b = {in_col_ff, 4'b0};
      neg_a = center_x_ff < pos_a;
      neg_b = center_y_ff < pos_b;
      num_a = neg_a ? pos_a - center_x_ff : center_x_ff - pos_a;
      num_b = neg_b ? pos_b - center_y_ff : center_y_ff - pos_b;
      s1_in.depth = in_depth_ff;
      s1_in.last  = in_last_ff;
      s1_in.a_nz  = num_a != '0;
      s1_in.b_nz  = num_b != '0;
      s1_in.a_neg = neg_a && s1_in.a_nz;
      s1_in.b_neg = neg_b && s1_in.b_nz;
   end

   // Ratio dividers, one per axis, with the side data delayed alongside.
   logic [DIV_NW-1:0] quo_a, quo_b;

   dpp_div u_div_a (
      .clock    (clock),
      .adv      (adv),
      .dividend (DIV_NW'({num_a, {RATIO_FRAC_BITS{1'b0}}})),
      .divisor  (DIV_DW'(focal_x_ff)),
      .quotient (quo_a)
   );

   dpp_div u_div_b (
      .clock    (clock),
      .adv      (adv),
      .dividend (DIV_NW'({num_b, {RATIO_FRAC_BITS{1'b0}}})),
      .divisor  (DIV_DW'(focal_y_ff)),
      .quotient (quo_b)
   );

   side1_type d1_ff [DIV_NW];

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff[0] <= s1_in;
         for (int k = 1; k < DIV_NW; k++) begin
            d1_ff[k] <= d1_ff[k-1];
         end
      end
   end

   // Stage P1: clamp the ratios.
   logic [RATIO_W-1:0] a_mag_ff, b_mag_ff, a_mag_in, b_mag_in;
   side1_type          p1_ff;

   assign a_mag_in = clamp_ratio(quo_a, focal_x_ff, d1_ff[DIV_NW-1].a_nz);
   assign b_mag_in = clamp_ratio(quo_b, focal_y_ff, d1_ff[DIV_NW-1].b_nz);

   always_ff @(posedge clock) begin
      if (adv) begin
         a_mag_ff <= a_mag_in;
         b_mag_ff <= b_mag_in;
         p1_ff    <= d1_ff[DIV_NW-1];
      end
   end

   // Stage P2: squares of the Q.16 ratios (in Q.32) and lateral products.
   logic [Q16_W-1:0]  a16, b16;
   logic [SQR_W-1:0]  sq_a_ff, sq_b_ff, sq_a_in, sq_b_in;
   logic [PROD_W-1:0] prod_a_ff, prod_b_ff, prod_a_in, prod_b_in;
   side1_type         p2_ff;

   always_comb begin
      a16       = to_q16(a_mag_ff);
      b16       = to_q16(b_mag_ff);
      sq_a_in   = SQR_W'(a16 * a16);
      sq_b_in   = SQR_W'(b16 * b16);
      prod_a_in = PROD_W'(a_mag_ff * p1_ff.depth);
      prod_b_in = PROD_W'(b_mag_ff * p1_ff.depth);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_a_ff   <= sq_a_in;
         sq_b_ff   <= sq_b_in;
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
         p2_ff     <= p1_ff;
      end
   end

   // Stage P3: sum of squares and saturated lateral terms.
   logic [SQ_IW-1:0] sum_ff, sum_in;
   side2_type        p3_ff, p3_in;

   always_comb begin
      sum_in        = NORM_ONE_SQ + SQ_IW'(sq_a_ff) + SQ_IW'(sq_b_ff);
      p3_in.lat_col = lateral(prod_b_ff, p2_ff.b_neg);
      p3_in.lat_row = lateral(prod_a_ff, p2_ff.a_neg);
      p3_in.depth   = p2_ff.depth;
      p3_in.last    = p2_ff.last;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= sum_in;
         p3_ff  <= p3_in;
      end
   end

   // Square root of the sum; the root is at least 65536.
   logic [ROOT_W-1:0] root;
   side2_type         d2_ff [ROOT_W];

   dpp_isqrt u_isqrt (
      .clock    (clock),
      .adv      (adv),
      .radicand (sum_ff),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         d2_ff[0] <= p3_ff;
         for (int k = 1; k < ROOT_W; k++) begin
            d2_ff[k] <= d2_ff[k-1];
         end
      end
   end

   // Range division: depth * 65536 / root.
   logic [DIV_NW-1:0] quo_r;
   side3_type         s3_in;
   side3_type         d3_ff [DIV_NW];

   dpp_div u_div_r (
      .clock    (clock),
      .adv      (adv),
      .dividend (DIV_NW'({d2_ff[ROOT_W-1].depth, 16'b0})),
      .divisor  (DIV_DW'(root)),
      .quotient (quo_r)
   );

   always_comb begin
      s3_in.lat_col = d2_ff[ROOT_W-1].lat_col;
      s3_in.lat_row = d2_ff[ROOT_W-1].lat_row;
      s3_in.last    = d2_ff[ROOT_W-1].last;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d3_ff[0] <= s3_in;
         for (int k = 1; k < DIV_NW; k++) begin
            d3_ff[k] <= d3_ff[k-1];
         end
      end
   end

   // Output register.
   logic [LAT_W-1:0]   out_col_ff, out_row_ff;
   logic [RANGE_W-1:0] out_range_ff;
   logic               out_last_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         out_col_ff   <= d3_ff[DIV_NW-1].lat_col;
         out_row_ff   <= d3_ff[DIV_NW-1].lat_row;
         out_range_ff <= quo_r[RANGE_W-1:0];
         out_last_ff  <= d3_ff[DIV_NW-1].last;
      end
   end

   assign rsp_lateral_col  = out_col_ff;
   assign rsp_lateral_row  = out_row_ff;
   assign rsp_range_scaled = out_range_ff;
   assign rsp_frame_end    = out_last_ff;

   // An accepted pixel occupies the first stage on the next cycle.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted item did not enter the pipeline");

   // The root of 1 + a^2 + b^2 in Q.16 never drops below one.
   a_root_ge_one: assert property (@(posedge clock) disable iff (reset)
      vld_ff[SQO_IDX] |-> root[ROOT_W-1:16] != '0)
      else $error("square root below one");

   // The scaled range never exceeds the depth, so it fits the output field.
   a_range_fits: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIVB_IDX] |-> quo_r[DIV_NW-1:RANGE_W] == '0)
      else $error("range quotient overflow");

   // Saturation is symmetric: the most negative code never appears.
   a_lat_sym: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> out_col_ff != LAT_MIN && out_row_ff != LAT_MIN)
      else $error("lateral term outside symmetric range");

endmodule
